// ===== rtl/core/vttr_pkg.sv =====
// Shared constants for the vertex transform to raster block.
`default_nettype none
package vttr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 14;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_POINT = 1'b1;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 14'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 14'd480;

    localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

// ===== rtl/core/vertex_transform_to_raster.sv =====
// Vertex transform, perspective divide and viewport mapping, fully pipelined.
//
//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+-----------------------------------------
//  s_        | in  | s_valid/s_ready   | op, element_index/value, point_x/y/z
//  m_        | out | m_valid/m_ready   | raster_x, raster_y, depth, divide_by_zero
//  cfg_      | in  | cfg_wr_en         | cfg_index, cfg_wdata (width, height)
//
// One request per cycle while the output is not stalled. A point passes stages 1
// to 5 and the divider, QW being its quotient bits (33 at 16 fraction bits), one
// restoring step per stage. Matrix writes finish at acceptance.
// Reset clears the matrix, valid bits and sets the raster size to 640x480.
// A stalled output freezes every stage at once; s_ready follows that stall.
`default_nettype none
module vertex_transform_to_raster #(
    parameter int FRAC_BITS = vttr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_index,
    input  wire logic [vttr_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_op,
    input  wire logic [3:0]                    s_element_index,
    input  wire logic signed [31:0]            s_element_value,
    input  wire logic signed [31:0]            s_point_x,
    input  wire logic signed [31:0]            s_point_y,
    input  wire logic signed [31:0]            s_point_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [31:0]                 m_raster_x,
    output logic signed [31:0]                 m_raster_y,
    output logic signed [31:0]                 m_depth,
    output logic                               m_divide_by_zero
);

    localparam int FB  = FRAC_BITS;
    localparam int CW  = vttr_pkg::CFG_W;
    // quotient bits kept: anything larger saturates after the offset add
    localparam int QW  = (FB + 14 > 32) ? FB + 15 : 33;
    localparam int UNW = 45;                // |x * size|
    localparam int SH  = QW - FB;
    localparam int R0W = UNW - SH;
    localparam int TW  = 66 - FB + 1;
    localparam int VW  = QW + 2;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic acc;
    assign acc = s_valid && s_ready;

    // configuration
    logic [CW-1:0] width_reg, height_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= vttr_pkg::WIDTH_RST;
            height_reg <= vttr_pkg::HEIGHT_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == vttr_pkg::CFG_IDX_WIDTH) width_reg  <= cfg_wdata;
            else                                      height_reg <= cfg_wdata;
        end
    end

    // matrix store, column major
    logic signed [31:0] mat_reg [16];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
        end else if (acc && s_op == vttr_pkg::OP_WRITE) begin
            mat_reg[s_element_index] <= s_element_value;
        end
    end

    // stage 1: nine products
    logic               v1_reg;
    logic signed [63:0] prod_reg [9];
    logic signed [31:0] t1_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= acc && s_op == vttr_pkg::OP_POINT;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                prod_reg[3*r]   <= mat_reg[r]     * s_point_x;
                prod_reg[3*r+1] <= mat_reg[4 + r] * s_point_y;
                prod_reg[3*r+2] <= mat_reg[8 + r] * s_point_z;
                t1_reg[r]       <= mat_reg[12 + r];
            end
        end
    end

    // stage 2: row sums
    logic               v2_reg;
    logic signed [65:0] sum_reg [3];
    logic signed [31:0] t2_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                sum_reg[r] <= prod_reg[3*r] + prod_reg[3*r+1] + prod_reg[3*r+2];
                t2_reg[r]  <= t1_reg[r];
            end
        end
    end

    // stage 3: floor shift, translation, saturate
    logic               v3_reg;
    logic signed [31:0] row_reg [3];
    logic signed [TW-1:0] row_full [3];
    always_comb begin
        for (int r = 0; r < 3; r++)
            row_full[r] = TW'(sum_reg[r] >>> FB) + TW'(t2_reg[r]);
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                if (row_full[r][TW-1:31] == '0 || row_full[r][TW-1:31] == '1)
                    row_reg[r] <= row_full[r][31:0];
                else
                    row_reg[r] <= row_full[r][TW-1] ? vttr_pkg::I32_MIN
                                                    : vttr_pkg::I32_MAX;
            end
        end
    end

    // stage 4: scale by raster size
    logic               v4_reg;
    logic signed [45:0] nx_reg, ny_reg;
    logic signed [31:0] z4_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= row_reg[0] * $signed({1'b0, width_reg});
            ny_reg <= row_reg[1] * $signed({1'b0, height_reg});
            z4_reg <= row_reg[2];
        end
    end

    // stage 5: magnitudes and signs
    logic               v5_reg;
    logic [UNW-1:0]     unx_reg, uny_reg;
    logic [32:0]        ud5_reg;
    logic               negx5_reg, negy5_reg;
    logic signed [31:0] z5_reg;
    logic signed [32:0] zext;
    logic signed [32:0] zabs;
    always_comb begin
        zext = {z4_reg[31], z4_reg};
        zabs = zext[32] ? -zext : zext;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en)  v5_reg <= v4_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            unx_reg   <= UNW'(nx_reg[45] ? -nx_reg : nx_reg);
            uny_reg   <= UNW'(ny_reg[45] ? -ny_reg : ny_reg);
            ud5_reg   <= {zabs[31:0], 1'b0};
            negx5_reg <= nx_reg[45] ^ z4_reg[31];
            negy5_reg <= ny_reg[45] ^ z4_reg[31];
            z5_reg    <= z4_reg;
        end
    end

    // divider pipeline, index 0 is the setup stage
    logic               dv_reg   [QW+1];
    logic [32:0]        drx_reg  [QW+1];
    logic [32:0]        dry_reg  [QW+1];
    logic [QW-1:0]      dnx_reg  [QW+1];
    logic [QW-1:0]      dny_reg  [QW+1];
    logic [QW-1:0]      dqx_reg  [QW+1];
    logic [QW-1:0]      dqy_reg  [QW+1];
    logic [32:0]        dud_reg  [QW+1];
    logic               dngx_reg [QW+1];
    logic               dngy_reg [QW+1];
    logic               dofx_reg [QW+1];
    logic               dofy_reg [QW+1];
    logic signed [31:0] dz_reg   [QW+1];

    logic [R0W-1:0] r0x, r0y;
    assign r0x = unx_reg[UNW-1:SH];
    assign r0y = uny_reg[UNW-1:SH];

    always_ff @(posedge aclk) begin
        if (!aresetn) dv_reg[0] <= 1'b0;
        else if (en)  dv_reg[0] <= v5_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            drx_reg[0]  <= 33'(r0x);
            dry_reg[0]  <= 33'(r0y);
            dofx_reg[0] <= 33'(r0x) >= ud5_reg;
            dofy_reg[0] <= 33'(r0y) >= ud5_reg;
            dnx_reg[0]  <= {unx_reg[SH-1:0], FB'(0)};
            dny_reg[0]  <= {uny_reg[SH-1:0], FB'(0)};
            dqx_reg[0]  <= '0;
            dqy_reg[0]  <= '0;
            dud_reg[0]  <= ud5_reg;
            dngx_reg[0] <= negx5_reg;
            dngy_reg[0] <= negy5_reg;
            dz_reg[0]   <= z5_reg;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [33:0] tx, ty;
        logic        bx, by;
        always_comb begin
            tx = {drx_reg[k], dnx_reg[k][QW-1]};
            ty = {dry_reg[k], dny_reg[k][QW-1]};
            bx = tx >= {1'b0, dud_reg[k]};
            by = ty >= {1'b0, dud_reg[k]};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) dv_reg[k+1] <= 1'b0;
            else if (en)  dv_reg[k+1] <= dv_reg[k];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                drx_reg[k+1]  <= bx ? 33'(tx - {1'b0, dud_reg[k]}) : tx[32:0];
                dry_reg[k+1]  <= by ? 33'(ty - {1'b0, dud_reg[k]}) : ty[32:0];
                dqx_reg[k+1]  <= {dqx_reg[k][QW-2:0], bx};
                dqy_reg[k+1]  <= {dqy_reg[k][QW-2:0], by};
                dnx_reg[k+1]  <= dnx_reg[k] << 1;
                dny_reg[k+1]  <= dny_reg[k] << 1;
                dud_reg[k+1]  <= dud_reg[k];
                dngx_reg[k+1] <= dngx_reg[k];
                dngy_reg[k+1] <= dngy_reg[k];
                dofx_reg[k+1] <= dofx_reg[k];
                dofy_reg[k+1] <= dofy_reg[k];
                dz_reg[k+1]   <= dz_reg[k];
            end
        end
    end

    // final stage: sign, center offset, saturation into the output register
    logic signed [VW-1:0] vx, vy, offx, offy, totx, toty;
    logic signed [31:0]   rx, ry;
    logic                 zero_z;
    always_comb begin
        vx   = dngx_reg[QW] ? -$signed({2'b00, dqx_reg[QW]}) : $signed({2'b00, dqx_reg[QW]});
        vy   = dngy_reg[QW] ? -$signed({2'b00, dqy_reg[QW]}) : $signed({2'b00, dqy_reg[QW]});
        offx = $signed(VW'({width_reg,  (FB-1)'(0)}));
        offy = $signed(VW'({height_reg, (FB-1)'(0)}));
        totx = vx + offx;
        toty = vy + offy;
        if (dofx_reg[QW])
            rx = dngx_reg[QW] ? vttr_pkg::I32_MIN : vttr_pkg::I32_MAX;
        else if (totx[VW-1:31] == '0 || totx[VW-1:31] == '1)
            rx = totx[31:0];
        else
            rx = totx[VW-1] ? vttr_pkg::I32_MIN : vttr_pkg::I32_MAX;
        if (dofy_reg[QW])
            ry = dngy_reg[QW] ? vttr_pkg::I32_MIN : vttr_pkg::I32_MAX;
        else if (toty[VW-1:31] == '0 || toty[VW-1:31] == '1)
            ry = toty[31:0];
        else
            ry = toty[VW-1] ? vttr_pkg::I32_MIN : vttr_pkg::I32_MAX;
        zero_z = dz_reg[QW] == '0;
    end

    logic               m_valid_reg;
    logic signed [31:0] m_rx_reg, m_ry_reg, m_depth_reg;
    logic               m_dz_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (en)  m_valid_reg <= dv_reg[QW];
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            m_rx_reg    <= zero_z ? '0 : rx;
            m_ry_reg    <= zero_z ? '0 : ry;
            m_depth_reg <= dz_reg[QW];
            m_dz_reg    <= zero_z;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_raster_x       = m_rx_reg;
    assign m_raster_y       = m_ry_reg;
    assign m_depth          = m_depth_reg;
    assign m_divide_by_zero = m_dz_reg;

`ifndef SYNTHESIS
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_raster_x == 0 && m_raster_y == 0 && m_depth == 0)
        else $error("zero depth result carries nonzero fields");
    a_flag_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_divide_by_zero |-> m_depth != 0)
        else $error("nonzero flag clear with zero depth");
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_vertex_transform_to_raster.sv =====
// Self-checking testbench for the vertex transform to raster block.
`default_nettype none
module tb_vertex_transform_to_raster;

    localparam int FB = vttr_pkg::FRAC_BITS_DEF;
    // pipeline depth is 7 + 33 divider stages; drain with margin
    localparam int DRAIN_CYCLES = 80;

    localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
    localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] dep;
        logic               dz;
    } raster_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = 1'b0;
    logic [vttr_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_op = 1'b0;
    logic [3:0] s_element_index = '0;
    logic signed [31:0] s_element_value = '0;
    logic signed [31:0] s_point_x = '0;
    logic signed [31:0] s_point_y = '0;
    logic signed [31:0] s_point_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_raster_x;
    logic signed [31:0] m_raster_y;
    logic signed [31:0] m_depth;
    logic m_divide_by_zero;

    vertex_transform_to_raster dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_element_index (s_element_index),
        .s_element_value (s_element_value),
        .s_point_x       (s_point_x),
        .s_point_y       (s_point_y),
        .s_point_z       (s_point_z),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_raster_x      (m_raster_x),
        .m_raster_y      (m_raster_y),
        .m_depth         (m_depth),
        .m_divide_by_zero(m_divide_by_zero)
    );

    // shadow state of the block
    logic signed [31:0]         matrix_shadow [16];
    logic [vttr_pkg::CFG_W-1:0] width_shadow;
    logic [vttr_pkg::CFG_W-1:0] height_shadow;

    raster_t pending_rasters[$];
    int      mismatches = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the handshake hangs
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
        if (v > SAT_HI) return SAT_HI[31:0];
        if (v < SAT_LO) return SAT_LO[31:0];
        return v[31:0];
    endfunction

    // one row: three products, floor shift, translation, saturate
    function automatic logic signed [31:0] xform_row(input int r,
            input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz);
        logic signed [79:0] a0, a1, a2, b0, b1, b2, t, acc;
        a0 = matrix_shadow[r];
        a1 = matrix_shadow[4 + r];
        a2 = matrix_shadow[8 + r];
        t  = matrix_shadow[12 + r];
        b0 = px;
        b1 = py;
        b2 = pz;
        acc = (a0 * b0 + a1 * b1 + a2 * b2) >>> FB;
        return clamp32(acc + t);
    endfunction

    // size/2 + c*size/(2z), quotient truncated toward zero
    function automatic logic signed [31:0] map_axis(input logic signed [31:0] c,
            input logic [vttr_pkg::CFG_W-1:0] size, input logic signed [31:0] z);
        logic signed [79:0] n, d, v, sz;
        logic [79:0] un, ud, ip, rm, mag;
        logic neg;
        sz  = {66'b0, size};
        n   = c;
        n   = n * sz;
        d   = z;
        d   = d * 2;
        neg = (n < 0) != (d < 0);
        un  = (n < 0) ? -n : n;
        ud  = (d < 0) ? -d : d;
        ip  = un / ud;
        rm  = un % ud;
        if (ip > 80'h1_0000_0000) ip = 80'h1_0000_0000;
        mag = (ip << FB) + ((rm << FB) / ud);
        v   = neg ? -$signed(mag) : $signed(mag);
        v   = v + (sz <<< (FB - 1));
        return clamp32(v);
    endfunction

    function automatic raster_t project_point(input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [31:0] pz);
        raster_t r;
        logic signed [31:0] x, y, z;
        x = xform_row(0, px, py, pz);
        y = xform_row(1, px, py, pz);
        z = xform_row(2, px, py, pz);
        if (z == 0) begin
            r = '{rx: 0, ry: 0, dep: 0, dz: 1'b1};
        end else begin
            r.rx  = map_axis(x, width_shadow, z);
            r.ry  = map_axis(y, height_shadow, z);
            r.dep = z;
            r.dz  = 1'b0;
        end
        return r;
    endfunction

    // receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        raster_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rasters.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result x=%h y=%h d=%h dz=%b", $time,
                         m_raster_x, m_raster_y, m_depth, m_divide_by_zero);
            end else begin
                want = pending_rasters.pop_front();
                if (m_raster_x !== want.rx) begin
                    mismatches++;
                    $display("%0t: raster_x expected %h actual %h", $time, want.rx, m_raster_x);
                end
                if (m_raster_y !== want.ry) begin
                    mismatches++;
                    $display("%0t: raster_y expected %h actual %h", $time, want.ry, m_raster_y);
                end
                if (m_depth !== want.dep) begin
                    mismatches++;
                    $display("%0t: depth expected %h actual %h", $time, want.dep, m_depth);
                end
                if (m_divide_by_zero !== want.dz) begin
                    mismatches++;
                    $display("%0t: divide_by_zero expected %b actual %b", $time,
                             want.dz, m_divide_by_zero);
                end
            end
        end
    end

    // one request on the input channel; the predictor runs at acceptance
    task automatic send_request(input logic op, input logic [3:0] idx,
            input logic signed [31:0] val, input logic signed [31:0] px,
            input logic signed [31:0] py, input logic signed [31:0] pz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_element_index <= idx;
        s_element_value <= val;
        s_point_x       <= px;
        s_point_y       <= py;
        s_point_z       <= pz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op == vttr_pkg::OP_WRITE) matrix_shadow[idx] = val;
        else pending_rasters.push_back(project_point(px, py, pz));
    endtask

    task automatic write_element(input logic [3:0] idx, input logic signed [31:0] val);
        send_request(vttr_pkg::OP_WRITE, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
            input logic signed [31:0] pz);
        send_request(vttr_pkg::OP_POINT, 4'($urandom), $urandom, px, py, pz);
    endtask

    // wait for every result, then let trailing matrix writes settle
    task automatic drain_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rasters.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_raster_size(input logic [vttr_pkg::CFG_W-1:0] w,
            input logic [vttr_pkg::CFG_W-1:0] h);
        drain_block();
        cfg_wr_en <= 1'b1;
        cfg_index <= vttr_pkg::CFG_IDX_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        width_shadow = w;
        cfg_index <= vttr_pkg::CFG_IDX_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        height_shadow = h;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // mix of magnitudes: full range, small, near unity, corner values
    function automatic logic signed [31:0] pick_fixed();
        case ($urandom_range(9))
            0, 1: return $urandom;
            2, 3, 4: return $signed($urandom_range(1 << 19)) - (1 << 18);
            5, 6: return $signed($urandom_range(1 << 17)) - (1 << 16);
            7: return 32'sh0001_0000;
            8: return 0;
            default: return ($urandom_range(1)) ? vttr_pkg::I32_MAX : vttr_pkg::I32_MIN;
        endcase
    endfunction

    // zero matrix after reset: every point lands at zero depth
    task automatic test_reset_matrix();
        send_point(vttr_pkg::I32_MAX, vttr_pkg::I32_MIN, 32'sh0001_0000);
        send_point(0, 0, 0);
    endtask

    // identity plus depth offset, corner points
    task automatic test_identity_view();
        write_element(4'd0, 32'sh0001_0000);
        write_element(4'd5, 32'sh0001_0000);
        write_element(4'd10, 32'sh0001_0000);
        write_element(4'd14, 32'sh0004_0000);
        send_point(32'sh0002_0000, -32'sh0001_8000, 32'sh0001_0000);
        send_point(0, 0, 0);
        send_point(vttr_pkg::I32_MAX, vttr_pkg::I32_MAX, vttr_pkg::I32_MAX);
        send_point(vttr_pkg::I32_MIN, vttr_pkg::I32_MIN, vttr_pkg::I32_MIN);
        // z cancels to zero: divide flag with nonzero x and y
        send_point(32'sh0001_0000, 32'sh0001_0000, -32'sh0004_0000);
        // tiny z: quotient saturates
        send_point(vttr_pkg::I32_MAX, vttr_pkg::I32_MIN, -32'sh0003_ffff);
    endtask

    task automatic test_extreme_matrix();
        write_element(4'd12, vttr_pkg::I32_MAX);
        write_element(4'd13, vttr_pkg::I32_MIN);
        write_element(4'd1, vttr_pkg::I32_MIN);
        write_element(4'd4, vttr_pkg::I32_MAX);
        write_element(4'd15, 32'sh1234_5678);
        send_point(vttr_pkg::I32_MIN, vttr_pkg::I32_MAX, 32'sh0000_0001);
        send_point(32'sh0000_0001, -32'sh0000_0001, vttr_pkg::I32_MIN);
        send_point(-32'sh0001_0000, 32'sh0003_0000, 0);
    endtask

    // well-formed matrix updates followed by point bursts, some noise
    task automatic test_random_stream(input int n_items, input int s_pct, input int r_pct);
        int sent;
        int burst;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            repeat ($urandom_range(3)) begin
                write_element(4'($urandom), pick_fixed());
                sent++;
            end
            if ($urandom_range(9) == 0) begin
                // clear the depth row so the zero-depth path is hit often
                write_element(4'd2, 0);
                write_element(4'd6, 0);
                write_element(4'd10, 0);
                write_element(4'd14, ($urandom_range(1)) ? 0 : pick_fixed());
                sent += 4;
            end
            burst = $urandom_range(12, 1);
            repeat (burst) begin
                send_point(pick_fixed(), pick_fixed(), pick_fixed());
                sent++;
            end
            // hold the sender until the block has emptied
            if ($urandom_range(40) == 0) drain_block();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
    endtask

    initial begin
        for (int i = 0; i < 16; i++) matrix_shadow[i] = 0;
        width_shadow  = vttr_pkg::WIDTH_RST;
        height_shadow = vttr_pkg::HEIGHT_RST;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_matrix();
        test_identity_view();
        test_extreme_matrix();

        test_random_stream(400, 33, 81);
        set_raster_size(14'd1, 14'd8192);
        test_random_stream(400, 81, 33);
        set_raster_size(14'd8192, 14'd1);
        test_random_stream(200, 0, 0);
        // outside the documented range: zero and all ones
        set_raster_size(14'd0, 14'h3fff);
        test_random_stream(200, 0, 0);

        drain_block();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/vttr_pkg.sv
rtl/core/vertex_transform_to_raster.sv
tb/tb_vertex_transform_to_raster.sv
